// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- design/qki_pkg.sv -----
package qki_pkg;

   // Encoder counts per mechanical detent (1..8).
   localparam int COUNTS_PER_DETENT = 4;
   // Default debounce history length (2..16).
   localparam int DEBOUNCE_LEN_DEF = 8;

   localparam logic [7:0] WINDOW_TICKS_RST  = 8'd50;
   localparam logic [7:0] VELOCITY_GAIN_RST = 8'd10;

   // Register indexes, taken from paddr[2].
   localparam logic REG_WINDOW_TICKS  = 1'b0;
   localparam logic REG_VELOCITY_GAIN = 1'b1;

   // Item kinds.
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // Read selectors.
   localparam logic [3:0] SEL_RELEASED = 4'd0;
   localparam logic [3:0] SEL_PRESSED  = 4'd1;
   localparam logic [3:0] SEL_HELD     = 4'd2;
   localparam logic [3:0] SEL_DETENT   = 4'd7;
   localparam logic [3:0] SEL_VELOCITY = 4'd8;

   // Full-resolution quadrature decode, index {previous_ab, current_ab}.
   localparam logic signed [1:0] STEP_TABLE [16] = '{
      2'sd0,  2'sd1, -2'sd1,  2'sd0,
     -2'sd1,  2'sd0,  2'sd0,  2'sd1,
      2'sd1,  2'sd0,  2'sd0, -2'sd1,
      2'sd0, -2'sd1,  2'sd1,  2'sd0
   };

   typedef struct packed {
      logic       kind;
      logic       enc_a_pin;
      logic       enc_b_pin;
      logic       button_pin;
      logic [3:0] read_select;
   } item_type;

   typedef struct packed {
      logic [7:0] window_ticks;
      logic [7:0] velocity_gain;
   } cfg_type;

endpackage

// ----- design/qki_channels.sv -----
interface qki_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic       enc_a_pin;
   logic       enc_b_pin;
   logic       button_pin;
   logic [3:0] read_select;

   modport source (output valid, kind, enc_a_pin, enc_b_pin, button_pin, read_select,
                   input ready);
   modport sink   (input valid, kind, enc_a_pin, enc_b_pin, button_pin, read_select,
                   output ready);
endinterface

interface qki_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] read_value;

   modport source (output valid, read_value, input ready);
   modport sink   (input valid, read_value, output ready);
endinterface

// ----- design/qki_core.sv -----
module qki_core #(
   parameter int DEBOUNCE_LEN = qki_pkg::DEBOUNCE_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_en,
   input  qki_pkg::item_type  item,
   input  qki_pkg::cfg_type   cfg,
   output logic signed [15:0] read_value
);

   localparam int CPD = qki_pkg::COUNTS_PER_DETENT;
   localparam logic signed [3:0] R_TOP = 4'(CPD - 1);
   localparam logic signed [3:0] R_BOT = 4'(1 - CPD);
   localparam logic signed [5:0] PART_POS = 6'(CPD);
   localparam logic signed [5:0] PART_NEG = 6'(-CPD);

   logic [1:0]              prev_ab_ff, prev_ab_in;
   logic                    prev_btn_ff, prev_btn_in;
   logic [DEBOUNCE_LEN-1:0] deb_ff, deb_in;
   logic signed [4:0]       part_ff, part_in;
   logic [7:0]              detent_ff, detent_in;
   // Window steps kept as truncated quotient and remainder by counts per detent.
   logic signed [9:0]       win_q_ff, win_q_in;
   logic signed [3:0]       win_r_ff, win_r_in;
   logic [7:0]              win_cnt_ff, win_cnt_in;
   logic [15:0]             vel_ff, vel_in;
   logic [2:0]              flags_ff, flags_in;

   logic [1:0]         cur_ab;
   logic signed [1:0]  step;
   logic signed [5:0]  part_sum;
   logic signed [9:0]  q_nx;
   logic signed [3:0]  r_nx;
   logic signed [18:0] prod;
   logic [15:0]        vel_sat;
   logic               win_hit;
   logic               held;

   assign cur_ab   = {~item.enc_b_pin, ~item.enc_a_pin};
   assign step     = qki_pkg::STEP_TABLE[{prev_ab_ff, cur_ab}];
   assign part_sum = 6'(part_ff) + 6'(step);
   assign win_hit  = (win_cnt_ff == cfg.window_ticks);
   assign deb_in   = {deb_ff[DEBOUNCE_LEN-2:0], ~item.button_pin};
   assign held     = &deb_in;

   // Quotient/remainder step with truncation toward zero.
   always_comb begin
      q_nx = win_q_ff;
      r_nx = win_r_ff;
      if (step == 2'sd1) begin
         if (win_r_ff == R_TOP) begin
            q_nx = win_q_ff + 10'sd1;
            r_nx = '0;
         end else if (win_r_ff == 4'sd0 && win_q_ff < 10'sd0) begin
            q_nx = win_q_ff + 10'sd1;
            r_nx = R_BOT;
         end else begin
            r_nx = win_r_ff + 4'sd1;
         end
      end else if (step == -2'sd1) begin
         if (win_r_ff == R_BOT) begin
            q_nx = win_q_ff - 10'sd1;
            r_nx = '0;
         end else if (win_r_ff == 4'sd0 && win_q_ff > 10'sd0) begin
            q_nx = win_q_ff - 10'sd1;
            r_nx = R_TOP;
         end else begin
            r_nx = win_r_ff - 4'sd1;
         end
      end
   end

   assign prod = 19'(q_nx) * 19'($signed({1'b0, cfg.velocity_gain}));

   always_comb begin
      if (prod > 19'sd32767) begin
         vel_sat = 16'h7FFF;
      end else if (prod < -19'sd32768) begin
         vel_sat = 16'h8000;
      end else begin
         vel_sat = prod[15:0];
      end
   end

   always_comb begin
      read_value = '0;
      unique case (item.read_select) inside
         qki_pkg::SEL_RELEASED, qki_pkg::SEL_PRESSED, qki_pkg::SEL_HELD: begin
            read_value = {15'd0, flags_ff[item.read_select[1:0]]};
         end
         qki_pkg::SEL_DETENT: begin
            read_value = {{8{detent_ff[7]}}, detent_ff};
         end
         qki_pkg::SEL_VELOCITY: begin
            read_value = vel_ff;
         end
         default: begin
            read_value = '0;
         end
      endcase
   end

   always_comb begin
      prev_ab_in  = prev_ab_ff;
      prev_btn_in = prev_btn_ff;
      part_in     = part_ff;
      detent_in   = detent_ff;
      win_q_in    = win_q_ff;
      win_r_in    = win_r_ff;
      win_cnt_in  = win_cnt_ff;
      vel_in      = vel_ff;
      flags_in    = flags_ff;
      if (item.kind == qki_pkg::KIND_TICK) begin
         prev_ab_in = cur_ab;
         part_in    = part_sum[4:0];
         if (part_sum == PART_POS) begin
            detent_in = detent_ff + 8'd1;
            part_in   = '0;
         end else if (part_sum == PART_NEG) begin
            detent_in = detent_ff - 8'd1;
            part_in   = '0;
         end
         win_q_in = q_nx;
         win_r_in = r_nx;
         if (win_hit) begin
            vel_in   = vel_sat;
            win_q_in = '0;
            win_r_in = '0;
         end
         win_cnt_in  = (win_hit ? 8'd0 : win_cnt_ff) + 8'd1;
         flags_in[2] = held;
         if (held && !prev_btn_ff) flags_in[1] = 1'b1;
         if (!held && prev_btn_ff) flags_in[0] = 1'b1;
         prev_btn_in = held;
      end else begin
         unique case (item.read_select) inside
            qki_pkg::SEL_RELEASED, qki_pkg::SEL_PRESSED, qki_pkg::SEL_HELD: begin
               flags_in[item.read_select[1:0]] = 1'b0;
            end
            qki_pkg::SEL_DETENT: begin
               detent_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ab_ff  <= '0;
         prev_btn_ff <= 1'b0;
         deb_ff      <= '0;
         part_ff     <= '0;
         detent_ff   <= '0;
         win_q_ff    <= '0;
         win_r_ff    <= '0;
         win_cnt_ff  <= '0;
         vel_ff      <= '0;
         flags_ff    <= '0;
      end else if (item_en) begin
         prev_ab_ff  <= prev_ab_in;
         prev_btn_ff <= prev_btn_in;
         if (item.kind == qki_pkg::KIND_TICK) begin
            deb_ff <= deb_in;
         end
         part_ff     <= part_in;
         detent_ff   <= detent_in;
         win_q_ff    <= win_q_in;
         win_r_ff    <= win_r_in;
         win_cnt_ff  <= win_cnt_in;
         vel_ff      <= vel_in;
         flags_ff    <= flags_in;
      end
   end

endmodule

// ----- design/quadrature_knob_interface.sv -----
// Quadrature knob interface: encoder decode, detent count, windowed velocity, button debounce.
// An accepted read goes into the input register, and its result into the result register.
// Throughput: one item per cycle unless a read stalls; input register -> state/result stage.
// A result waiting in the output register holds a read behind it, and the input with it.
// Reset (synchronous, active high) clears all knob state and flags and loads
// window_ticks = 50, velocity_gain = 10.
`include "assert_macros.svh"

module quadrature_knob_interface #(
   parameter int DEBOUNCE_LEN = qki_pkg::DEBOUNCE_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   qki_req_if.sink     req_chan,
   qki_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------------------------------------------------------
   // Configuration registers (APB, zero wait states)
   // ---------------------------------------------------------------
   qki_pkg::cfg_type cfg_ff, cfg_in;
   logic             csr_wr;
   logic             csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            qki_pkg::REG_WINDOW_TICKS:  cfg_in.window_ticks  = csr_pwdata[7:0];
            qki_pkg::REG_VELOCITY_GAIN: cfg_in.velocity_gain = csr_pwdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         qki_pkg::REG_WINDOW_TICKS:  csr_prdata = {24'd0, cfg_ff.window_ticks};
         qki_pkg::REG_VELOCITY_GAIN: csr_prdata = {24'd0, cfg_ff.velocity_gain};
         default:                    csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Input register: holds one accepted item until the state stage
   // can take it. A tick always moves on; a read waits only while the
   // result register is full and not being drained.
   // ---------------------------------------------------------------
   logic              s1_valid_ff, s1_valid_in;
   qki_pkg::item_type s1_item_ff;
   logic              s1_adv;
   logic              s1_is_read;
   logic              req_xfer;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_data_ff;
   logic signed [15:0] core_value;

   assign s1_is_read = (s1_item_ff.kind == qki_pkg::KIND_READ);
   assign s1_adv     = s1_valid_ff && (!s1_is_read || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_xfer   = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Knob state and read mux
   // ---------------------------------------------------------------
   qki_core #(
      .DEBOUNCE_LEN (DEBOUNCE_LEN)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_en    (s1_adv),
      .item       (s1_item_ff),
      .cfg        (cfg_ff),
      .read_value (core_value)
   );

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_is_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ticks  <= qki_pkg::WINDOW_TICKS_RST;
         cfg_ff.velocity_gain <= qki_pkg::VELOCITY_GAIN_RST;
         s1_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_xfer) begin
         s1_item_ff.kind        <= req_chan.kind;
         s1_item_ff.enc_a_pin   <= req_chan.enc_a_pin;
         s1_item_ff.enc_b_pin   <= req_chan.enc_b_pin;
         s1_item_ff.button_pin  <= req_chan.button_pin;
         s1_item_ff.read_select <= req_chan.read_select;
      end
      if (s1_adv && s1_is_read) begin
         rsp_data_ff <= core_value;
      end
   end

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // A read leaving the input register always lands in the result register.
   `ASSERT_NEXT(a_read_gives_result, clock, reset, s1_adv && s1_is_read, rsp_valid_ff, "read lost")

   // A tick never produces a result of its own.
   `ASSERT_NEXT(a_tick_no_result, clock, reset,
                s1_adv && !s1_is_read && !req_xfer && (!rsp_valid_ff || rsp_chan.ready),
                !rsp_valid_ff, "tick produced a result")

   // A stalled read behind a full result register blocks new input.
   `ASSERT_NOW(a_stall_blocks_input, clock, reset,
               s1_valid_ff && s1_is_read && rsp_valid_ff && !rsp_chan.ready,
               !req_chan.ready, "input accepted over a stalled read")

   // The held item is not overwritten while it waits.
   `ASSERT_NEXT(a_item_holds, clock, reset, s1_valid_ff && !s1_adv,
                s1_valid_ff && $stable(s1_item_ff), "waiting item changed")

endmodule

// ----- bench/quadrature_knob_interface_test.sv -----
// Tracks the knob state from the accepted transfers and holds the readouts still due.
class knob_readout_scoreboard;
   localparam int HISTORY_LEN = qki_pkg::DEBOUNCE_LEN_DEF;

   logic [7:0]             close_at;
   logic [7:0]             gain;
   logic [1:0]             prior_phase;
   logic                   btn_stable;
   logic [HISTORY_LEN-1:0] btn_history;
   int                     sub_detent;
   logic [7:0]             detents;
   logic signed [9:0]      span_steps;
   logic [7:0]             span_ticks;
   logic [15:0]            speed;
   logic [2:0]             flags;

   logic signed [15:0] pending_readouts[$];
   int fails;
   int readouts;

   function new();
      close_at    = qki_pkg::WINDOW_TICKS_RST;
      gain        = qki_pkg::VELOCITY_GAIN_RST;
      prior_phase = '0;
      btn_stable  = 1'b0;
      btn_history = '0;
      sub_detent  = 0;
      detents     = '0;
      span_steps  = '0;
      span_ticks  = '0;
      speed       = '0;
      flags       = '0;
      fails       = 0;
      readouts    = 0;
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      fails++;
   endtask

   function void set_register(logic index, logic [7:0] value);
      if (index == qki_pkg::REG_WINDOW_TICKS) close_at = value;
      else gain = value;
   endfunction

   // Gray position of an active-high {B, A} pair around the code wheel.
   function int shaft_position(logic [1:0] ab);
      case (ab)
         2'b00: return 0;
         2'b01: return 1;
         2'b11: return 2;
         default: return 3;
      endcase
   endfunction

   function void advance_tick(qki_pkg::item_type it);
      logic [1:0] now_phase;
      int         delta;
      int         step;
      int         span;
      int         gain_i;
      int         v;
      logic       held;
      now_phase = {~it.enc_b_pin, ~it.enc_a_pin};
      delta = (shaft_position(now_phase) - shaft_position(prior_phase)) & 3;
      step = (delta == 1) ? 1 : (delta == 3) ? -1 : 0;
      span_steps = span_steps + 10'(step);
      sub_detent += step;
      if (sub_detent == qki_pkg::COUNTS_PER_DETENT) begin
         detents = detents + 8'd1;
         sub_detent = 0;
      end
      if (sub_detent == -qki_pkg::COUNTS_PER_DETENT) begin
         detents = detents - 8'd1;
         sub_detent = 0;
      end
      if (span_ticks == close_at) begin
         span = int'(span_steps);
         gain_i = int'(gain);
         v = (span / qki_pkg::COUNTS_PER_DETENT) * gain_i;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         speed = 16'(v);
         span_steps = '0;
         span_ticks = '0;
      end
      btn_history = {btn_history[HISTORY_LEN-2:0], ~it.button_pin};
      held = &btn_history;
      flags[2] = held;
      if (held && !btn_stable) flags[1] = 1'b1;
      if (!held && btn_stable) flags[0] = 1'b1;
      btn_stable = held;
      prior_phase = now_phase;
      span_ticks = span_ticks + 8'd1;
   endfunction

   function logic [15:0] sample_register(logic [3:0] sel);
      logic [15:0] v;
      case (sel) inside
         qki_pkg::SEL_RELEASED, qki_pkg::SEL_PRESSED, qki_pkg::SEL_HELD: begin
            v = {15'd0, flags[sel[1:0]]};
            flags[sel[1:0]] = 1'b0;
         end
         qki_pkg::SEL_DETENT: begin
            v = {{8{detents[7]}}, detents};
            detents = '0;
         end
         qki_pkg::SEL_VELOCITY: v = speed;
         default: v = '0;
      endcase
      return v;
   endfunction

   function void note_transfer(qki_pkg::item_type it);
      if (it.kind == qki_pkg::KIND_TICK) advance_tick(it);
      else pending_readouts.push_back(sample_register(it.read_select));
   endfunction

   task check_readout(logic signed [15:0] got);
      logic signed [15:0] want;
      readouts++;
      if (pending_readouts.size() == 0) begin
         report($sformatf("readout %0d = %0d arrived with nothing pending", readouts, got));
      end else begin
         want = pending_readouts.pop_front();
         if (got !== want)
            report($sformatf("readout %0d: read_value %0d, want %0d", readouts, got, want));
      end
   endtask
endclass

module quadrature_knob_interface_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles with no transfer of any kind before the run is declared hung.
   localparam int QUIET_LIMIT   = 5000;
   // Let the pipe empty before touching registers.
   localparam int SETTLE_CYCLES = 4;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   qki_req_if req_bus();
   qki_rsp_if rsp_bus();

   quadrature_knob_interface i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   knob_readout_scoreboard tracker;

   // Sender burst bookkeeping.
   int burst_left = 0;

   // Knob gesture state: shaft position on the code wheel, current run direction,
   // and the button level with the ticks it has left at that level.
   int shaft_pos = 0;
   int shaft_dir = 0;
   int shaft_run = 0;
   bit btn_down  = 1'b0;
   int btn_left  = 0;

   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver stall pattern: a 16-bit ready mask, walked bit by bit and re-rolled.
   // Bit 0 is always set so a stall never outlasts one mask period.
   initial begin
      logic [15:0] ready_mask;
      int          beat;
      ready_mask = '1;
      beat = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (beat % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: ready_mask = '1;
               1: ready_mask = 16'($urandom) & 16'($urandom) | 16'd1;
               default: ready_mask = 16'($urandom) | 16'd1;
            endcase
         end
         rsp_bus.ready <= ready_mask[beat % 16];
         beat++;
      end
   end

   // Result monitor: every accepted result transfer goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_readout(rsp_bus.read_value);
   end

   // Watchdog: counts cycles in which nothing moves on any port.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // One input transfer. Bursts of random length, random gaps between them;
   // a zero gap keeps valid high across items.
   task automatic send_item(qki_pkg::item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= it.kind;
      req_bus.enc_a_pin   <= it.enc_a_pin;
      req_bus.enc_b_pin   <= it.enc_b_pin;
      req_bus.button_pin  <= it.button_pin;
      req_bus.read_select <= it.read_select;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_transfer(it);
   endtask

   // Pin sample; read_select is don't-care on ticks, so it gets noise.
   task automatic tick(logic a_pin, logic b_pin, logic btn_pin);
      qki_pkg::item_type it;
      it.kind        = qki_pkg::KIND_TICK;
      it.enc_a_pin   = a_pin;
      it.enc_b_pin   = b_pin;
      it.button_pin  = btn_pin;
      it.read_select = 4'($urandom);
      send_item(it);
   endtask

   // Register read; pin fields are don't-care on reads.
   task automatic peek(logic [3:0] sel);
      qki_pkg::item_type it;
      it.kind        = qki_pkg::KIND_READ;
      it.enc_a_pin   = 1'($urandom);
      it.enc_b_pin   = 1'($urandom);
      it.button_pin  = 1'($urandom);
      it.read_select = sel;
      send_item(it);
   endtask

   // Stop sending, wait until every readout is back, then let the pipe drain.
   task automatic drain_and_settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_readouts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write followed by a read-back of the same register.
   task automatic csr_write(logic index, logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_register(index, value);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== value)
         tracker.report($sformatf("register %0d reads %0h, written %0h",
                                  index, csr_prdata[7:0], value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [7:0] window, logic [7:0] gain);
      drain_and_settle();
      csr_write(qki_pkg::REG_WINDOW_TICKS, window);
      csr_write(qki_pkg::REG_VELOCITY_GAIN, gain);
   endtask

   // One random item. Mostly clean quadrature runs with a bouncy button,
   // some reads, a little pin noise. In spin mode the shaft only turns forward
   // and the detent count is left alone so it wraps.
   task automatic knob_gesture(bit spin);
      int         pick;
      logic [3:0] sel;
      bit         glitch;
      pick = $urandom_range(0, 99);
      if (pick < (spin ? 6 : 22)) begin
         pick = $urandom_range(0, 15);
         if (pick < 3) sel = qki_pkg::SEL_RELEASED;
         else if (pick < 5) sel = qki_pkg::SEL_PRESSED;
         else if (pick < 7) sel = qki_pkg::SEL_HELD;
         else if (pick < 10) sel = qki_pkg::SEL_DETENT;
         else if (pick < 13) sel = qki_pkg::SEL_VELOCITY;
         else sel = 4'($urandom_range(0, 15));
         if (spin && sel == qki_pkg::SEL_DETENT) sel = qki_pkg::SEL_VELOCITY;
         peek(sel);
      end else if (!spin && pick >= 93) begin
         // broken sequence: arbitrary pin levels
         tick(1'($urandom), 1'($urandom), 1'($urandom));
      end else begin
         if (shaft_run == 0) begin
            shaft_run = $urandom_range(1, 12);
            shaft_dir = spin ? 1 : int'($urandom_range(0, 2)) - 1;
         end
         shaft_run--;
         shaft_pos = (shaft_pos + shaft_dir) & 3;
         // short holds bounce the debouncer, long ones get through it
         if (btn_left == 0) begin
            btn_down = !btn_down;
            btn_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7)
                                                   : $urandom_range(8, 30);
         end
         btn_left--;
         glitch = ($urandom_range(0, 29) == 0);
         tick(!(shaft_pos == 1 || shaft_pos == 2), !(shaft_pos >= 2), !(btn_down ^ glitch));
      end
   endtask

   initial begin
      tracker = new();
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= qki_pkg::KIND_TICK;
      req_bus.enc_a_pin   <= 1'b1;
      req_bus.enc_b_pin   <= 1'b1;
      req_bus.button_pin  <= 1'b1;
      req_bus.read_select <= qki_pkg::SEL_RELEASED;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reads straight out of reset, including an unused selector.
      peek(qki_pkg::SEL_VELOCITY);
      peek(qki_pkg::SEL_DETENT);
      peek(4'd15);
      // One detent forward through all four phases, then one back.
      tick(1'b0, 1'b1, 1'b1);
      tick(1'b0, 1'b0, 1'b1);
      tick(1'b1, 1'b0, 1'b1);
      tick(1'b1, 1'b1, 1'b1);
      peek(qki_pkg::SEL_DETENT);
      tick(1'b1, 1'b0, 1'b1);
      tick(1'b0, 1'b0, 1'b1);
      tick(1'b0, 1'b1, 1'b1);
      tick(1'b1, 1'b1, 1'b1);
      peek(qki_pkg::SEL_DETENT);
      // Illegal double-phase jumps decode as no step.
      tick(1'b0, 1'b0, 1'b1);
      tick(1'b1, 1'b1, 1'b1);
      // Button held through the full debounce history: pressed and held.
      repeat (qki_pkg::DEBOUNCE_LEN_DEF) tick(1'b1, 1'b1, 1'b0);
      peek(qki_pkg::SEL_HELD);
      peek(qki_pkg::SEL_HELD);      // cleared by the read until the next tick
      peek(qki_pkg::SEL_PRESSED);
      tick(1'b1, 1'b1, 1'b1);   // one inactive sample drops held: released
      peek(qki_pkg::SEL_RELEASED);
      peek(qki_pkg::SEL_PRESSED);

      // Random at reset settings.
      repeat (250) knob_gesture(1'b0);

      // Shortest window, top gain: velocity latches on every tick.
      configure(8'd1, 8'd255);
      repeat (250) knob_gesture(1'b0);

      // Window of 255, top gain, steady forward spin past the detent wrap.
      configure(8'd255, 8'd255);
      repeat (560) knob_gesture(1'b1);
      peek(qki_pkg::SEL_DETENT);
      peek(qki_pkg::SEL_VELOCITY);

      // Zero window register: window closes when the tick counter wraps.
      configure(8'd0, 8'd0);
      repeat (300) knob_gesture(1'b0);

      configure(8'($urandom_range(2, 254)), 8'($urandom_range(1, 254)));
      repeat (200) knob_gesture(1'b0);

      drain_and_settle();
      if (tracker.fails == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
